FILE: rtl/clcd_pkg.sv
package clcd_pkg;

    // Operation codes on the input channel
    localparam logic [2:0] OP_WRITE_CHAR = 3'd0;
    localparam logic [2:0] OP_SET_POS    = 3'd1;
    localparam logic [2:0] OP_CLEAR      = 3'd2;
    localparam logic [2:0] OP_FLIP_LINE  = 3'd3;
    localparam logic [2:0] OP_WRITE_AT   = 3'd4;
    localparam logic [2:0] OP_BLANK_AT   = 3'd5;
    localparam logic [2:0] OP_INIT       = 3'd6;

    // Register select values
    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    // Display command bytes
    localparam logic [7:0] CMD_CLEAR       = 8'h01;
    localparam logic [7:0] CMD_HOME_4BIT   = 8'h02;
    localparam logic [7:0] CMD_FUNC_4BIT   = 8'h28;
    localparam logic [7:0] CMD_FUNC_8BIT   = 8'h38;
    localparam logic [7:0] CMD_DISPLAY_ON  = 8'h0C;
    localparam logic [7:0] CMD_SET_DDRAM   = 8'h80;
    localparam logic [7:0] CHAR_SPACE      = 8'h20;
    localparam logic [7:0] NIBBLE_MASK     = 8'hF0;

    // Register map (word index taken from paddr[2])
    localparam logic REG_BUS_MODE = 1'b0;
    localparam logic REG_VIS_COLS = 1'b1;
    localparam logic [5:0] VIS_COLS_RESET = 6'd16;

    // Most bytes any single operation produces (init in 4-bit mode)
    localparam int MAX_BYTES = 5;

    typedef struct packed {
        logic [2:0] operation;
        logic       row;
        logic [5:0] column;
        logic [7:0] char_code;
        logic       keep_position;
    } in_t;

    typedef struct packed {
        logic       reg_select;
        logic [7:0] bus_byte;
        logic       last;
    } out_t;

    typedef struct packed {
        logic       rs;
        logic [7:0] data;
    } xfer_t;

    // One operation after decode: up to MAX_BYTES bus bytes
    typedef struct packed {
        logic [2:0]                 count;
        xfer_t [MAX_BYTES-1:0]      xfers;
    } job_t;

    function automatic xfer_t cmd_xfer(input logic [7:0] b);
        xfer_t x;
        x.rs   = RS_CMD;
        x.data = b;
        return x;
    endfunction

    function automatic xfer_t data_xfer(input logic [7:0] b);
        xfer_t x;
        x.rs   = RS_DATA;
        x.data = b;
        return x;
    endfunction

    function automatic xfer_t set_xfer(input logic r, input logic [5:0] c);
        xfer_t x;
        x.rs   = RS_CMD;
        x.data = CMD_SET_DDRAM | {1'b0, r, c};
        return x;
    endfunction

endpackage

FILE: rtl/clcd_front.sv
module clcd_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  clcd_pkg::in_t       s_data,
    input  logic                bus_mode,
    input  logic [5:0]          vis_cols,
    input  logic                q_full,
    output logic                q_push,
    output clcd_pkg::job_t      q_job
);

    logic       row_reg, row_next;
    logic [5:0] col_reg, col_next;
    logic [5:0] vis;
    logic       take;
    clcd_pkg::job_t job;

    assign vis     = (vis_cols == 6'd0) ? 6'd1 : vis_cols;
    assign s_ready = !q_full;
    assign take    = s_valid && s_ready;

    always_comb begin
        job      = '0;
        row_next = row_reg;
        col_next = col_reg;
        case (s_data.operation)
            clcd_pkg::OP_WRITE_CHAR: begin
                if (col_reg >= vis) begin
                    // wrap onto the other line
                    row_next      = ~row_reg;
                    col_next      = 6'd1;
                    job.xfers[0]  = clcd_pkg::set_xfer(~row_reg, 6'd0);
                    job.xfers[1]  = clcd_pkg::data_xfer(s_data.char_code);
                    job.count     = 3'd2;
                end else begin
                    col_next      = col_reg + 6'd1;
                    job.xfers[0]  = clcd_pkg::data_xfer(s_data.char_code);
                    job.count     = 3'd1;
                end
            end
            clcd_pkg::OP_SET_POS: begin
                row_next     = s_data.row;
                col_next     = s_data.column;
                job.xfers[0] = clcd_pkg::set_xfer(s_data.row, s_data.column);
                job.count    = 3'd1;
            end
            clcd_pkg::OP_CLEAR: begin
                job.xfers[0] = clcd_pkg::cmd_xfer(clcd_pkg::CMD_CLEAR);
                if (s_data.keep_position) begin
                    job.xfers[1] = clcd_pkg::set_xfer(row_reg, col_reg);
                end else begin
                    row_next     = 1'b0;
                    col_next     = 6'd0;
                    job.xfers[1] = clcd_pkg::set_xfer(1'b0, 6'd0);
                end
                job.count = 3'd2;
            end
            clcd_pkg::OP_FLIP_LINE: begin
                row_next     = ~row_reg;
                job.xfers[0] = clcd_pkg::set_xfer(~row_reg, col_reg);
                job.count    = 3'd1;
            end
            clcd_pkg::OP_WRITE_AT, clcd_pkg::OP_BLANK_AT: begin
                // cursor ends where it was
                job.xfers[0] = clcd_pkg::set_xfer(s_data.row, s_data.column);
                job.xfers[1] = clcd_pkg::data_xfer(
                    (s_data.operation == clcd_pkg::OP_WRITE_AT) ?
                    s_data.char_code : clcd_pkg::CHAR_SPACE);
                job.xfers[2] = clcd_pkg::set_xfer(row_reg, col_reg);
                job.count    = 3'd3;
            end
            clcd_pkg::OP_INIT: begin
                row_next = 1'b0;
                col_next = 6'd0;
                if (bus_mode) begin
                    job.xfers[0] = clcd_pkg::cmd_xfer(clcd_pkg::CMD_HOME_4BIT);
                    job.xfers[1] = clcd_pkg::cmd_xfer(clcd_pkg::CMD_FUNC_4BIT);
                    job.xfers[2] = clcd_pkg::cmd_xfer(clcd_pkg::CMD_DISPLAY_ON);
                    job.xfers[3] = clcd_pkg::cmd_xfer(clcd_pkg::CMD_CLEAR);
                    job.xfers[4] = clcd_pkg::set_xfer(1'b0, 6'd0);
                    job.count    = 3'd5;
                end else begin
                    job.xfers[0] = clcd_pkg::cmd_xfer(clcd_pkg::CMD_FUNC_8BIT);
                    job.xfers[1] = clcd_pkg::cmd_xfer(clcd_pkg::CMD_DISPLAY_ON);
                    job.xfers[2] = clcd_pkg::cmd_xfer(clcd_pkg::CMD_CLEAR);
                    job.xfers[3] = clcd_pkg::set_xfer(1'b0, 6'd0);
                    job.count    = 3'd4;
                end
            end
            default: begin
                // unused code: dropped, no transfers
                job = '0;
            end
        endcase
    end

    assign q_push = take && (job.count != 3'd0);
    assign q_job  = job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= 1'b0;
            col_reg <= 6'd0;
        end else if (take) begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

FILE: rtl/clcd_fifo.sv
module clcd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  clcd_pkg::job_t      push_job,
    output logic                full,
    input  logic                pop,
    output clcd_pkg::job_t      head,
    output logic                empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    clcd_pkg::job_t  mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   cnt_reg;
    logic            do_push, do_pop;

    assign full    = (cnt_reg == FULL_CNT);
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

FILE: rtl/clcd_back.sv
module clcd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                bus_mode,
    input  clcd_pkg::job_t      head,
    input  logic                q_empty,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output clcd_pkg::out_t      m_data
);

    logic [2:0]      idx_reg;
    logic            half_reg;
    logic            out_valid_reg;
    clcd_pkg::out_t  out_reg;
    clcd_pkg::xfer_t cur;
    clcd_pkg::out_t  beat;
    logic            advance, load, byte_done, job_done;

    assign cur       = head.xfers[idx_reg];
    assign byte_done = !bus_mode || half_reg;
    assign job_done  = byte_done && (idx_reg == head.count - 3'd1);

    always_comb begin
        beat.reg_select = cur.rs;
        if (!bus_mode) begin
            beat.bus_byte = cur.data;
        end else if (!half_reg) begin
            beat.bus_byte = cur.data & clcd_pkg::NIBBLE_MASK;
        end else begin
            beat.bus_byte = {cur.data[3:0], 4'h0};
        end
        beat.last = job_done;
    end

    // output stage refills whenever it is empty or being drained
    assign advance = !out_valid_reg || m_ready;
    assign load    = advance && !q_empty;
    assign q_pop   = load && job_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= 3'd0;
            half_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= load;
            if (load) begin
                if (!byte_done) begin
                    half_reg <= 1'b1;
                end else begin
                    half_reg <= 1'b0;
                    idx_reg  <= job_done ? 3'd0 : idx_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_reg <= beat;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

FILE: rtl/char_lcd_command_sequencer.sv
// Character display command sequencer.
// Input channel (s_valid/s_ready/s_data): one host operation per transfer
// (write char, set position, clear, flip line, write at, blank at, init).
// Result channel (m_valid/m_ready/m_data): one display bus transfer per beat,
// register select plus byte; in 4-bit mode each byte goes out as two beats,
// high nibble first in bits 7..4. m_data.last marks an operation's final beat.
// APB port: register 0 = bus_mode (bit 0), register 1 = visible_columns
// (bits 5..0, 0 acts as 1). Write only while the block is idle.
// The decoded job is registered in the queue; the back end then loads each
// beat into the output register that drives m_valid and m_data.
// The result side sends one beat per cycle while m_ready is high and a job
// is queued; an operation is 1 to 10 beats (init in 4-bit mode is the longest).
// The input side takes one operation per cycle while the decoded-job queue
// (QUEUE_DEPTH entries) has room; the single beat-per-cycle output register
// sets the sustained rate.
// When the receiver stalls, the output register holds its beat, the queue
// fills, and then s_ready drops. Unused operation codes are taken and dropped.
// Reset: cursor goes to row 0 column 0, bus_mode 0, visible_columns 16,
// queue and output empty.
module char_lcd_command_sequencer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    // host operations
    input  logic            s_valid,
    output logic            s_ready,
    input  clcd_pkg::in_t   s_data,
    // bus transfers
    output logic            m_valid,
    input  logic            m_ready,
    output clcd_pkg::out_t  m_data,
    // configuration
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    logic            bus_mode_reg;
    logic [5:0]      vis_cols_reg;
    logic            cfg_wr;

    logic            q_push, q_pop, q_full, q_empty;
    clcd_pkg::job_t  q_in, q_head;

    // config registers: word select on paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bus_mode_reg <= 1'b0;
            vis_cols_reg <= clcd_pkg::VIS_COLS_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                clcd_pkg::REG_BUS_MODE: bus_mode_reg <= pwdata[0];
                clcd_pkg::REG_VIS_COLS: vis_cols_reg <= pwdata[5:0];
                default:                bus_mode_reg <= bus_mode_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            clcd_pkg::REG_BUS_MODE: prdata = {31'd0, bus_mode_reg};
            clcd_pkg::REG_VIS_COLS: prdata = {26'd0, vis_cols_reg};
            default:                prdata = 32'd0;
        endcase
    end

    // front: decode op, track cursor, build byte list
    clcd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .bus_mode (bus_mode_reg),
        .vis_cols (vis_cols_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (q_in)
    );

    // decoded jobs wait here so front and back stall independently
    clcd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    // back: walk bytes/nibbles of the head job into the output register
    clcd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .bus_mode (bus_mode_reg),
        .head     (q_head),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

FILE: rtl/clcd_checker.sv
module clcd_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            m_valid,
    input logic            m_ready,
    input clcd_pkg::out_t  m_data,
    input logic            pready,
    input logic [31:0]     prdata
);

    // held beat while the display side stalls
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_pready: assert property (@(posedge aclk)
        pready)
        else $error("pready low");

    a_prdata_narrow: assert property (@(posedge aclk)
        prdata[31:6] == 26'd0)
        else $error("read data has bits above the register fields");

endmodule

bind char_lcd_command_sequencer clcd_checker u_clcd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data),
    .pready  (pready),
    .prdata  (prdata)
);
